// ----- hw/rtl/ccns_pkg.sv -----
// Shared types and constants for the codebook cosine nearest search block.
package ccns_pkg;

  localparam int CFG_W   = 9;
  localparam int ELEM_W  = 16;
  localparam int SIM_W   = 16;
  localparam int IDX_W   = 4;
  localparam int OP_W    = 2;
  localparam int STS_W   = 2;

  localparam int NORM_SHIFT = 20;
  localparam int FRAC_SHIFT = 14;
  localparam int T_LIMIT_W  = 40;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_ANS = 1'b1;

  localparam logic signed [SIM_W-1:0] SIM_ONE   = 16'sh4000;
  localparam logic signed [SIM_W-1:0] SIM_EMPTY = 16'sh8000;

  localparam logic [CFG_W-1:0] VLEN_RESET = 9'd256;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_SQA,
    S_SQB,
    S_DIVA,
    S_DIVB,
    S_CMP,
    S_EMIT
  } ccns_state_t;

  typedef struct packed {
    logic load_elem;
    logic query_elem;
    logic clear;
    logic sqrt_start;
    logic sqrt_sel_b;
    logic div_start;
    logic div_sel_b;
    logic compare;
    logic pass_next;
    logic emit;
  } ccns_cmd_t;

  typedef struct packed {
    logic load_last;
    logic query_last;
    logic cb_empty;
    logic pass_done;
    logic sqrt_done;
    logic div_done;
    logic more_entries;
    logic out_free;
  } ccns_sts_t;

endpackage

// ----- hw/rtl/ccns_sqrt.sv -----
// Bit-serial integer square root, two radicand bits per cycle.
module ccns_sqrt
  import ccns_pkg::*;
#(
  parameter int SQ_W = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [SQ_W/2-1:0] root,
  output logic              done
);

  localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (SQ_W - 2);

  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] v_r, v_nxt;
  logic [SQ_W-1:0] r_r, r_nxt;
  logic [SQ_W-1:0] b_r;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial = r_r + b_r;
    if (v_r >= trial) begin
      v_nxt = v_r - trial;
      r_nxt = (r_r >> 1) + b_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= radicand;
      r_r <= '0;
      b_r <= TOP_BIT;
    end else if (busy_r) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
      b_r <= b_r >> 2;
    end
  end

  assign root = r_r[SQ_W/2-1:0];
  assign done = done_r;

endmodule

// ----- hw/rtl/ccns_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ccns_div
  import ccns_pkg::*;
#(
  parameter int DV_W = 59,
  parameter int RT_W = 30
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DV_W-1:0] dividend,
  input  logic [RT_W-1:0] divisor,
  output logic [DV_W-1:0] quotient,
  output logic            done
);

  localparam int CNT_W = $clog2(DV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DV_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DV_W-1:0]  n_r;
  logic [RT_W-1:0]  rem_r, rem_nxt;
  logic [RT_W-1:0]  dvs_r;
  logic [RT_W:0]    trial;
  logic             qbit;

  always_comb begin
    trial = {rem_r, n_r[DV_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      qbit    = 1'b1;
      rem_nxt = RT_W'(trial - {1'b0, dvs_r});
    end else begin
      qbit    = 1'b0;
      rem_nxt = trial[RT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      n_r   <= {n_r[DV_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = n_r;
  assign done     = done_r;

endmodule

// ----- hw/rtl/ccns_ctrl.sv -----
// Sequencing state machine for loads, queries and result hand-off.
module ccns_ctrl
  import ccns_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_opcode,
  output logic            in_stall,
  input  ccns_sts_t       sts,
  output ccns_cmd_t       cmd
);

  ccns_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD: begin
              if (sts.load_last) state_nxt = S_EMIT;
            end
            OP_QUERY: begin
              if (sts.query_last) state_nxt = sts.cb_empty ? S_EMIT : S_PASS;
            end
            default: ;
          endcase
        end
      end
      S_PASS: if (sts.pass_done) state_nxt = S_SQA;
      S_SQA:  if (sts.sqrt_done) state_nxt = S_SQB;
      S_SQB:  if (sts.sqrt_done) state_nxt = S_DIVA;
      S_DIVA: if (sts.div_done) state_nxt = S_DIVB;
      S_DIVB: if (sts.div_done) state_nxt = S_CMP;
      S_CMP:  state_nxt = sts.more_entries ? S_PASS : S_EMIT;
      S_EMIT: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            OP_LOAD:  cmd.load_elem  = 1'b1;
            OP_QUERY: cmd.query_elem = 1'b1;
            OP_CLEAR: cmd.clear      = 1'b1;
            default: ;
          endcase
        end
      end
      S_PASS: cmd.sqrt_start = sts.pass_done;
      S_SQA: begin
        cmd.sqrt_start = sts.sqrt_done;
        cmd.sqrt_sel_b = 1'b1;
      end
      S_SQB: cmd.div_start = sts.sqrt_done;
      S_DIVA: begin
        cmd.div_start = sts.div_done;
        cmd.div_sel_b = 1'b1;
      end
      S_DIVB: ;
      S_CMP: begin
        cmd.compare   = 1'b1;
        cmd.pass_next = sts.more_entries;
      end
      S_EMIT: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/ccns_dpath.sv -----
// Datapath: codebook and query stores, dot product pass, norms, output register.
module ccns_dpath
  import ccns_pkg::*;
#(
  parameter int DIM     = 256,
  parameter int ENTRIES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CFG_W-1:0]        vlen,
  input  logic signed [ELEM_W-1:0] elem,
  input  ccns_cmd_t               cmd,
  output ccns_sts_t               sts,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic                    out_result_kind,
  output logic [IDX_W-1:0]        out_entry_index,
  output logic signed [SIM_W-1:0] out_similarity,
  output logic [STS_W-1:0]        out_status
);

  localparam int LEN_W  = $clog2(DIM + 1);
  localparam int POS_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int CB_D   = ENTRIES * DIM;
  localparam int CB_AW  = (CB_D > 1) ? $clog2(CB_D) : 1;
  localparam int NORM_W = 31 + $clog2(DIM);
  localparam int DOT_W  = NORM_W + 1;
  localparam int SQ_W   = ((NORM_W + NORM_SHIFT + 1) / 2) * 2;
  localparam int RT_W   = SQ_W / 2;
  localparam int DV_A   = NORM_W + NORM_SHIFT;
  localparam int DV_B   = T_LIMIT_W + FRAC_SHIFT;
  localparam int DV_W   = (DV_A > DV_B) ? DV_A : DV_B;

  logic signed [ELEM_W-1:0] cb_mem [CB_D];
  logic signed [ELEM_W-1:0] q_mem  [DIM];
  logic [NORM_W-1:0]        ne_mem [ENTRIES];

  logic [LEN_W-1:0]  len_eff;
  logic [CW-1:0]     count_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  qpos_r;
  logic [NORM_W-1:0] nacc_r;
  logic [KW-1:0]     k_r;

  logic              room;
  logic              load_last;
  logic              query_last;
  logic signed [31:0] sq_e;
  logic [NORM_W-1:0] nacc_sum;
  logic [CB_AW-1:0]  cb_waddr;
  logic [CB_AW-1:0]  cb_raddr;

  logic              pass_act_r;
  logic              iss_r;
  logic [POS_W-1:0]  i_r;
  logic              v1_r, v2_r;
  logic signed [ELEM_W-1:0] q_rd_r, c_rd_r;
  logic signed [31:0] p_qe_r, p_qq_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [NORM_W-1:0] nq_r;
  logic [NORM_W-1:0] ne_r;
  logic              pass_done;
  logic              pass_init;
  logic              iss_last;

  logic [SQ_W-1:0]   sq_in;
  logic [RT_W-1:0]   sq_root;
  logic              sq_done;
  logic              sq_sel_r;
  logic [RT_W-1:0]   ra_r, rb_r;

  logic [DV_W-1:0]   dv_in;
  logic [RT_W-1:0]   dv_dvs;
  logic [DV_W-1:0]   dv_q;
  logic              dv_done;
  logic              dv_sel_r;
  logic [DV_W-1:0]   t_r, s_r;

  logic [NORM_W-1:0] mag;
  logic [SIM_W-1:0]  mag_s;
  logic signed [SIM_W-1:0] cand;
  logic [KW+IDX_W-1:0] k_ext;
  logic [KW+IDX_W-1:0] cnt_ext;

  logic              pk_r;
  logic [IDX_W-1:0]  pidx_r;
  logic signed [SIM_W-1:0] psim_r;
  logic [STS_W-1:0]  pst_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic signed [SIM_W-1:0] out_sim_r;
  logic [STS_W-1:0]  out_st_r;
  logic              out_free;

  always_comb begin
    if (vlen == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(vlen) > DIM) begin
      len_eff = LEN_W'(DIM);
    end else begin
      len_eff = LEN_W'(vlen);
    end
  end

  assign room       = (count_r < CW'(ENTRIES));
  assign load_last  = ((LEN_W+1)'(pos_r) + 1'b1) >= (LEN_W+1)'(len_eff);
  assign query_last = ((LEN_W+1)'(qpos_r) + 1'b1) >= (LEN_W+1)'(len_eff);
  assign sq_e       = elem * elem;
  assign nacc_sum   = nacc_r + NORM_W'($unsigned(sq_e));
  assign cb_waddr   = CB_AW'(count_r) * CB_AW'(DIM) + CB_AW'(pos_r);
  assign cb_raddr   = CB_AW'(k_r) * CB_AW'(DIM) + CB_AW'(i_r);
  assign k_ext      = (KW+IDX_W)'(k_r);
  assign cnt_ext    = (KW+IDX_W)'(count_r);

  // load and query bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
      qpos_r  <= '0;
      nacc_r  <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      pos_r   <= '0;
      qpos_r  <= '0;
      nacc_r  <= '0;
    end else if (cmd.load_elem) begin
      if (load_last) begin
        pos_r  <= '0;
        nacc_r <= '0;
        if (room) count_r <= count_r + 1'b1;
      end else begin
        pos_r <= pos_r + 1'b1;
        if (room) nacc_r <= nacc_sum;
      end
    end else if (cmd.query_elem) begin
      qpos_r <= query_last ? '0 : qpos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_elem && room) cb_mem[cb_waddr] <= elem;
    c_rd_r <= cb_mem[cb_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.query_elem) q_mem[qpos_r] <= elem;
    q_rd_r <= q_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_elem && room && load_last) ne_mem[count_r[KW-1:0]] <= nacc_sum;
    ne_r <= ne_mem[k_r];
  end

  // dot product and query norm pass
  assign pass_init = (cmd.query_elem && query_last && (count_r != '0)) || cmd.pass_next;
  assign pass_done = pass_act_r && !iss_r && !v1_r && !v2_r;
  assign iss_last  = ((LEN_W+1)'(i_r) + 1'b1) >= (LEN_W+1)'(len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_act_r <= 1'b0;
      iss_r      <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      k_r        <= '0;
      i_r        <= '0;
    end else begin
      v1_r <= iss_r;
      v2_r <= v1_r;
      if (pass_init) begin
        pass_act_r <= 1'b1;
        iss_r      <= 1'b1;
        i_r        <= '0;
        k_r        <= cmd.pass_next ? k_r + 1'b1 : '0;
      end else begin
        if (pass_done) pass_act_r <= 1'b0;
        if (iss_r) begin
          i_r <= i_r + 1'b1;
          if (iss_last) iss_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_qe_r <= q_rd_r * c_rd_r;
    p_qq_r <= q_rd_r * q_rd_r;
    if (pass_init) begin
      dot_r <= '0;
      nq_r  <= '0;
    end else if (v2_r) begin
      dot_r <= dot_r + DOT_W'(p_qe_r);
      nq_r  <= nq_r + NORM_W'($unsigned(p_qq_r));
    end
  end

  // norm roots and the two divisions; the second divide starts on the
  // cycle the first one finishes, so its dividend comes from the quotient
  assign sq_in  = cmd.sqrt_sel_b ? (SQ_W'(ne_r) << NORM_SHIFT) : (SQ_W'(nq_r) << NORM_SHIFT);
  assign mag    = dot_r[DOT_W-1] ? NORM_W'(-dot_r) : NORM_W'(dot_r);
  assign dv_in  = cmd.div_sel_b ? (DV_W'(dv_q[T_LIMIT_W-1:0]) << FRAC_SHIFT)
                                : (DV_W'(mag) << NORM_SHIFT);
  assign dv_dvs = cmd.div_sel_b ? rb_r : ra_r;

  ccns_sqrt #(.SQ_W(SQ_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_in),
    .root     (sq_root),
    .done     (sq_done)
  );

  ccns_div #(.DV_W(DV_W), .RT_W(RT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dv_in),
    .divisor  (dv_dvs),
    .quotient (dv_q),
    .done     (dv_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) sq_sel_r <= cmd.sqrt_sel_b;
    if (cmd.div_start) dv_sel_r <= cmd.div_sel_b;
    if (sq_done) begin
      if (sq_sel_r) rb_r <= sq_root;
      else ra_r <= sq_root;
    end
    if (dv_done) begin
      if (dv_sel_r) s_r <= dv_q;
      else t_r <= dv_q;
    end
  end

  always_comb begin
    if (nq_r == '0 || ne_r == '0) begin
      mag_s = '0;
    end else if (t_r[DV_W-1:T_LIMIT_W] != '0) begin
      mag_s = SIM_ONE;
    end else if (s_r > DV_W'(SIM_ONE)) begin
      mag_s = SIM_ONE;
    end else begin
      mag_s = s_r[SIM_W-1:0];
    end
    cand = dot_r[DOT_W-1] ? -$signed(mag_s) : $signed(mag_s);
  end

  // pending result, best match tracking
  always_ff @(posedge clk) begin
    if (cmd.load_elem && load_last) begin
      pk_r   <= KIND_ACK;
      psim_r <= '0;
      pidx_r <= room ? cnt_ext[IDX_W-1:0] : '0;
      pst_r  <= room ? STS_OK : STS_FULL;
    end else if (cmd.query_elem && query_last) begin
      pk_r   <= KIND_ANS;
      psim_r <= SIM_EMPTY;
      pidx_r <= '0;
      pst_r  <= (count_r == '0) ? STS_EMPTY : STS_OK;
    end else if (cmd.compare && (cand > psim_r)) begin
      psim_r <= cand;
      pidx_r <= k_ext[IDX_W-1:0];
    end
  end

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= pk_r;
      out_idx_r  <= pidx_r;
      out_sim_r  <= psim_r;
      out_st_r   <= pst_r;
    end
  end

  always_comb begin
    sts              = '0;
    sts.load_last    = load_last;
    sts.query_last   = query_last;
    sts.cb_empty     = (count_r == '0);
    sts.pass_done    = pass_done;
    sts.sqrt_done    = sq_done;
    sts.div_done     = dv_done;
    sts.more_entries = (CW'(k_r) + 1'b1) < count_r;
    sts.out_free     = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_entry_index = out_idx_r;
  assign out_similarity  = out_sim_r;
  assign out_status      = out_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above capacity");

  a_pass_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pass_act_r |-> (count_r != '0))
    else $error("search pass with empty codebook");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result emitted over a held word");

  a_cmp_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.compare |-> !pass_act_r)
    else $error("compare while pass still running");

endmodule

// ----- hw/rtl/codebook_cosine_nearest_search.sv -----
// Top level of the codebook cosine nearest search block.
//
//  channel  dir  handshake           payload
//  in_      in   in_valid/in_stall   in_opcode, in_element_value
//  out_     out  out_valid/out_stall out_result_kind, out_entry_index,
//                                    out_similarity, out_status
//  cfg_     in   cfg_valid/cfg_ready cfg_data (vector_length)
//
// Load, clear and non-final query words are taken in the idle state; a word that
// yields a result then hands it to the output register.
// The final query word runs per stored entry a dot product pass over the vector
// length, two serial root runs, two serial divides and a compare.
// Reset is synchronous; stores need no clearing pass.
// A held output word blocks only a word that yields a result; in_stall is
// high while busy.
module codebook_cosine_nearest_search
  import ccns_pkg::*;
#(
  parameter int DIM     = 256,
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_result_kind,
  output logic [IDX_W-1:0]         out_entry_index,
  output logic signed [SIM_W-1:0]  out_similarity,
  output logic [STS_W-1:0]         out_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data
);

  logic [CFG_W-1:0] vlen_r;
  ccns_cmd_t        cmd;
  ccns_sts_t        sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vlen_r <= cfg_data;
    end
  end

  ccns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccns_dpath #(.DIM(DIM), .ENTRIES(ENTRIES)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .vlen            (vlen_r),
    .elem            (in_element_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_entry_index (out_entry_index),
    .out_similarity  (out_similarity),
    .out_status      (out_status)
  );

endmodule

// ----- sim/tb.sv -----
// Testbench for codebook_cosine_nearest_search: directed table plus random vectors.
`timescale 1ns / 100ps

module tb;
  import ccns_pkg::*;

  localparam int DEPTH = 256;
  localparam int SLOTS = 16;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         idx;
    logic signed [SIM_W-1:0]  sim;
    logic [STS_W-1:0]         sts;
  } answer_t;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [ELEM_W-1:0] val;
    bit                      typed;
    answer_t                 ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = OP_LOAD;
  logic signed [ELEM_W-1:0] in_element_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_result_kind;
  logic [IDX_W-1:0] out_entry_index;
  logic signed [SIM_W-1:0] out_similarity;
  logic [STS_W-1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  codebook_cosine_nearest_search DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [CFG_W-1:0]         vlen;
  logic signed [ELEM_W-1:0] cb_mem [SLOTS*DEPTH];
  longint unsigned          cb_norm [SLOTS];
  logic signed [ELEM_W-1:0] q_mem [DEPTH];
  int unsigned              n_entries, load_pos, q_pos;
  longint unsigned          load_norm;

  answer_t pending_answers [$];
  int errors = 0;
  int send_idle = 0, stall_pct = 0;

  function automatic int unsigned eff_len();
    if (vlen == 0) return 1;
    if (vlen > DEPTH) return DEPTH;
    return vlen;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int cos_q14(longint dot, longint unsigned nq, longint unsigned ne);
    longint unsigned mag, ra, rb, t, s;
    if (nq == 0 || ne == 0) return 0;
    mag = (dot < 0) ? longint'(-dot) : longint'(dot);
    ra = int_sqrt(nq << NORM_SHIFT);
    rb = int_sqrt(ne << NORM_SHIFT);
    t = (mag << NORM_SHIFT) / ra;
    if (t >= (64'd1 << T_LIMIT_W)) s = 16384;
    else s = (t << FRAC_SHIFT) / rb;
    if (s > 16384) s = 16384;
    return (dot < 0) ? -int'(s) : int'(s);
  endfunction

  // advances the predictor by one accepted word; returns 1 when a result is due
  function automatic bit predict_word(logic [OP_W-1:0] op, logic signed [ELEM_W-1:0] v,
                                      output answer_t a);
    int unsigned len;
    bit room, last;
    longint unsigned nq;
    longint dot;
    int best, s;
    int unsigned best_k;
    len = eff_len();
    a = '0;
    case (op)
      OP_LOAD: begin
        room = n_entries < SLOTS;
        last = load_pos + 1 >= len;
        if (room) begin
          cb_mem[n_entries*DEPTH + load_pos] = v;
          load_norm += longint'(v) * longint'(v);
        end
        if (!last) begin
          load_pos++;
          return 0;
        end
        a.kind = KIND_ACK;
        if (room) begin
          cb_norm[n_entries] = load_norm;
          a.idx = n_entries[IDX_W-1:0];
          a.sts = STS_OK;
          n_entries++;
        end else begin
          a.sts = STS_FULL;
        end
        load_pos = 0;
        load_norm = 0;
        return 1;
      end
      OP_QUERY: begin
        q_mem[q_pos] = v;
        if (q_pos + 1 < len) begin
          q_pos++;
          return 0;
        end
        q_pos = 0;
        nq = 0;
        for (int i = 0; i < len; i++) nq += longint'(q_mem[i]) * longint'(q_mem[i]);
        best = -32768;
        best_k = 0;
        for (int k = 0; k < n_entries; k++) begin
          dot = 0;
          for (int i = 0; i < len; i++) dot += longint'(q_mem[i]) * longint'(cb_mem[k*DEPTH + i]);
          s = cos_q14(dot, nq, cb_norm[k]);
          if (s > best) begin
            best = s;
            best_k = k;
          end
        end
        a.kind = KIND_ANS;
        a.idx = best_k[IDX_W-1:0];
        a.sim = best[SIM_W-1:0];
        a.sts = (n_entries == 0) ? STS_EMPTY : STS_OK;
        return 1;
      end
      OP_CLEAR: begin
        n_entries = 0;
        load_pos = 0;
        q_pos = 0;
        load_norm = 0;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic signed [ELEM_W-1:0] v,
                           bit typed = 0, answer_t typed_ans = '0);
    answer_t a;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_word(op, v, a)) pending_answers.push_back(typed ? typed_ans : a);
  endtask

  task automatic write_length(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vlen = v;
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3, 4: return ELEM_W'($urandom_range(511)) - 16'sd256;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic random_words(int n);
    int sent, len, pick;
    sent = 0;
    while (sent < n) begin
      len = eff_len();
      pick = $urandom_range(99);
      if (pick < 62) begin
        for (int i = 0; i < len; i++) send_word(OP_LOAD, rand_elem());
        sent += len;
      end else if (pick < 92) begin
        for (int i = 0; i < len; i++) send_word(OP_QUERY, rand_elem());
        sent += len;
      end else if (pick < 95) begin
        send_word(OP_CLEAR, rand_elem());
        sent++;
      end else if (pick < 98) begin
        send_word(OP_NONE, rand_elem());
      end else begin
        // broken vector: partial load or query, then clear
        for (int i = 0; i < $urandom_range(len - 1); i++)
          send_word(pick[0] ? OP_LOAD : OP_QUERY, rand_elem());
        send_word(OP_CLEAR, rand_elem());
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_result_kind, out_entry_index, out_similarity, out_status};
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: kind %0d/%0d idx %0d/%0d sim %0d/%0d sts %0d/%0d (exp/got)",
                     want.kind, got.kind, want.idx, got.idx, want.sim, got.sim,
                     want.sts, got.sts);
        end
      end
    end
  end

  row_t dir_rows [] = '{
    '{OP_QUERY, 16'sd100,   1, '{KIND_ANS, 4'd0, SIM_EMPTY, STS_EMPTY}},
    '{OP_LOAD,  16'sh7fff,  1, '{KIND_ACK, 4'd0, 16'sd0, STS_OK}},
    '{OP_LOAD,  16'sh8000,  1, '{KIND_ACK, 4'd1, 16'sd0, STS_OK}},
    '{OP_LOAD,  16'sd0,     1, '{KIND_ACK, 4'd2, 16'sd0, STS_OK}},
    '{OP_QUERY, 16'sd0,     1, '{KIND_ANS, 4'd0, 16'sd0, STS_OK}},
    '{OP_QUERY, 16'sh8000,  0, '0},
    '{OP_QUERY, 16'sh7fff,  0, '0},
    '{OP_NONE,  16'sd5,     0, '0},
    '{OP_LOAD,  -16'sd4096, 1, '{KIND_ACK, 4'd3, 16'sd0, STS_OK}},
    '{OP_QUERY, 16'sd12345, 0, '0},
    '{OP_QUERY, -16'sd1,    0, '0},
    '{OP_CLEAR, 16'sd7,     0, '0},
    '{OP_QUERY, 16'sd1,     1, '{KIND_ANS, 4'd0, SIM_EMPTY, STS_EMPTY}},
    '{OP_LOAD,  16'sd1,     1, '{KIND_ACK, 4'd0, 16'sd0, STS_OK}},
    '{OP_QUERY, 16'sd300,   0, '0}
  };

  initial begin
    vlen = VLEN_RESET;
    n_entries = 0;
    load_pos = 0;
    q_pos = 0;
    load_norm = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_length(9'd1);
    foreach (dir_rows[i]) send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                                    dir_rows[i].ans);
    // fill past capacity to reach the full status
    for (int i = 0; i < SLOTS + 2; i++) send_word(OP_LOAD, rand_elem());

    write_length(9'd0);
    send_word(OP_CLEAR, 16'sd0);
    random_words(150);

    write_length(9'd3);
    send_idle = 75;
    send_word(OP_CLEAR, 16'sd0);
    random_words(150);

    write_length(9'd8);
    send_idle = 0;
    stall_pct = 75;
    send_word(OP_CLEAR, 16'sd0);
    random_words(150);

    write_length(9'd2);
    send_idle = 6;
    stall_pct = 6;
    send_word(OP_CLEAR, 16'sd0);
    random_words(150);

    write_length(9'd511);
    send_idle = 0;
    stall_pct = 0;
    send_word(OP_CLEAR, 16'sd0);
    for (int i = 0; i < DEPTH; i++) send_word(OP_LOAD, rand_elem());
    for (int i = 0; i < DEPTH; i++) send_word(OP_QUERY, rand_elem());

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
